>>> hw/rtl/assert_macros.svh
// Assertion macros used by the block's port checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CFA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cfa assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define CFA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cfa assertion failed");

`endif

>>> hw/rtl/cfa_pkg.sv
// Shared types and constants for the column filter/aggregate block.
`timescale 1ns / 1ps
package cfa_pkg;

  localparam int DATA_W     = 64;
  localparam int MAX_ROWS   = 65536;
  localparam int ROW_W      = $clog2(MAX_ROWS);
  localparam int OUT_ROW_W  = 16;
  localparam int CNT_W      = 17;
  localparam int OP_W       = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  localparam logic [CNT_W-1:0]  COUNT_MAX = '1;
  localparam logic [DATA_W-1:0] SUM_MAX   = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] SUM_MIN   = {1'b1, {(DATA_W-1){1'b0}}};

  // Predicate codes
  typedef enum logic [OP_W-1:0] {
    PRED_EQ      = 3'd0,
    PRED_NE      = 3'd1,
    PRED_LT      = 3'd2,
    PRED_GT      = 3'd3,
    PRED_LE      = 3'd4,
    PRED_GE      = 3'd5,
    PRED_BETWEEN = 3'd6,
    PRED_NEVER   = 3'd7
  } pred_op_t;

  // Aggregate codes; 5..7 are undefined and give no aggregate
  typedef enum logic [OP_W-1:0] {
    AGG_COUNT = 3'd0,
    AGG_SUM   = 3'd1,
    AGG_AVG   = 3'd2,
    AGG_MIN   = 3'd3,
    AGG_MAX   = 3'd4
  } agg_op_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PRED_OP    = 2'd0,
    CFG_BOUND_LOW  = 2'd1,
    CFG_BOUND_HIGH = 2'd2,
    CFG_AGG_OP     = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    pred_op_t          op;
    logic [DATA_W-1:0] low;
    logic [DATA_W-1:0] high;
  } pred_cfg_t;

  // One classified row as it travels from front to back
  typedef struct packed {
    logic [ROW_W-1:0]  row_index;
    logic [DATA_W-1:0] value;
    logic              is_null;
    logic              last_row;
    logic              hit;
  } row_entry_t;

  // Queue control between front, queue and back
  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  // Request to the serial divider
  typedef struct packed {
    logic              start;
    logic [DATA_W-1:0] dividend;
    logic [CNT_W-1:0]  divisor;
  } div_req_t;

endpackage

>>> hw/rtl/cfa_front.sv
// Front end: accepts rows, numbers them and applies the predicate.
`timescale 1ns / 1ps
module cfa_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [cfa_pkg::DATA_W-1:0] in_cell_value,
  input  logic                              in_cell_is_null,
  input  logic                              in_last_row,
  input  cfa_pkg::pred_cfg_t                pred_cfg,
  input  cfa_pkg::fifo_stat_t               fifo_stat,
  output logic                              push,
  output cfa_pkg::row_entry_t               push_entry
);
  import cfa_pkg::*;

  logic [ROW_W-1:0] row_r, row_nxt;
  logic             hit;

  assign in_ready = !fifo_stat.full;
  assign push     = in_valid && in_ready;

  // Predicate test, signed compares against the bounds
  always_comb begin
    unique case (pred_cfg.op)
      PRED_EQ:      hit = in_cell_value == $signed(pred_cfg.low);
      PRED_NE:      hit = in_cell_value != $signed(pred_cfg.low);
      PRED_LT:      hit = in_cell_value <  $signed(pred_cfg.low);
      PRED_GT:      hit = in_cell_value >  $signed(pred_cfg.low);
      PRED_LE:      hit = in_cell_value <= $signed(pred_cfg.low);
      PRED_GE:      hit = in_cell_value >= $signed(pred_cfg.low);
      PRED_BETWEEN: hit = (in_cell_value >= $signed(pred_cfg.low)) &&
                          (in_cell_value <= $signed(pred_cfg.high));
      default:      hit = 1'b0;
    endcase
  end

  assign push_entry = '{row_index: row_r,
                        value:     in_cell_value,
                        is_null:   in_cell_is_null,
                        last_row:  in_last_row,
                        hit:       hit && !in_cell_is_null};

  // Row counter: wraps at the column limit, restarts after the last row
  always_comb begin
    row_nxt = row_r;
    if (push) begin
      if (in_last_row || row_r == ROW_W'(MAX_ROWS - 1)) begin
        row_nxt = '0;
      end else begin
        row_nxt = row_r + ROW_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
    end else begin
      row_r <= row_nxt;
    end
  end

endmodule

>>> hw/rtl/cfa_fifo.sv
// Short queue of classified rows between front and back.
`timescale 1ns / 1ps
module cfa_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  cfa_pkg::row_entry_t  push_entry,
  input  logic                 pop,
  output cfa_pkg::row_entry_t  head,
  output cfa_pkg::fifo_stat_t  stat
);
  import cfa_pkg::*;

  row_entry_t         mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_AW:0]   count_r;

  assign head       = mem_r[rd_ptr_r];
  assign stat.full  = count_r == (FIFO_AW + 1)'(FIFO_DEPTH);
  assign stat.empty = count_r == '0;

  // Storage, no reset needed
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + FIFO_AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + FIFO_AW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + (FIFO_AW + 1)'(1);
      end else if (pop && !push) begin
        count_r <= count_r - (FIFO_AW + 1)'(1);
      end
    end
  end

endmodule

>>> hw/rtl/cfa_div.sv
// Restoring divider, one quotient bit per cycle, for the average.
`timescale 1ns / 1ps
module cfa_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  cfa_pkg::div_req_t          req,
  output logic                       busy,
  output logic [cfa_pkg::DATA_W-1:0] quotient
);
  import cfa_pkg::*;

  localparam int STEP_W = $clog2(DATA_W);

  logic                busy_r;
  logic [STEP_W-1:0]   step_r;
  logic [CNT_W-1:0]    rem_r, den_r;
  logic [DATA_W-1:0]   quo_r;
  logic [CNT_W:0]      shifted, diff;
  logic                ge;

  assign busy     = busy_r;
  assign quotient = quo_r;

  // One shift-subtract step
  always_comb begin
    shifted = {rem_r, quo_r[DATA_W-1]};
    diff    = shifted - {1'b0, den_r};
    ge      = shifted >= {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else if (req.start) begin
      busy_r <= 1'b1;
      step_r <= '0;
      rem_r  <= '0;
      quo_r  <= req.dividend;
      den_r  <= req.divisor;
    end else if (busy_r) begin
      rem_r  <= ge ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
      quo_r  <= {quo_r[DATA_W-2:0], ge};
      step_r <= step_r + STEP_W'(1);
      if (step_r == STEP_W'(DATA_W - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

endmodule

>>> hw/rtl/cfa_back.sv
// Back end: accumulates rows, forms the column aggregate, drives results.
`timescale 1ns / 1ps
module cfa_back (
  input  logic                               clk,
  input  logic                               rst_n,
  input  cfa_pkg::fifo_stat_t                fifo_stat,
  input  cfa_pkg::row_entry_t                head,
  output logic                               pop,
  input  logic [cfa_pkg::OP_W-1:0]           agg_op,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [cfa_pkg::OUT_ROW_W-1:0]      out_row_index,
  output logic                               out_is_match,
  output logic                               out_aggregate_valid,
  output logic signed [cfa_pkg::DATA_W-1:0]  out_aggregate_value,
  output logic                               out_used_all_rows,
  output logic                               out_sum_saturated
);
  import cfa_pkg::*;

  typedef enum logic [1:0] {ST_RUN, ST_FIN, ST_DIV} state_t;

  typedef struct packed {
    logic [CNT_W-1:0]  count;
    logic [DATA_W-1:0] sum;
    logic [DATA_W-1:0] lo;
    logic [DATA_W-1:0] hi;
    logic              sat;
  } acc_t;

  localparam acc_t ACC_CLEAR = '{count: '0, sum: '0, lo: SUM_MAX, hi: SUM_MIN, sat: 1'b0};

  // Add one value: saturating count and sum, running min and max
  function automatic acc_t acc_add(acc_t a, logic [DATA_W-1:0] v);
    acc_t          r;
    logic [DATA_W:0] s;
    r = a;
    s = {v[DATA_W-1], v} + {a.sum[DATA_W-1], a.sum};
    if (a.count != COUNT_MAX) begin
      r.count = a.count + CNT_W'(1);
    end
    if (s[DATA_W] != s[DATA_W-1]) begin
      r.sum = v[DATA_W-1] ? SUM_MIN : SUM_MAX;
      r.sat = 1'b1;
    end else begin
      r.sum = s[DATA_W-1:0];
    end
    if ($signed(v) < $signed(a.lo)) begin
      r.lo = v;
    end
    if ($signed(v) > $signed(a.hi)) begin
      r.hi = v;
    end
    return r;
  endfunction

  state_t            state_r, state_nxt;
  acc_t              match_r, match_nxt, total_r, total_nxt;
  logic [ROW_W-1:0]  fin_row_r, fin_row_nxt;
  logic              fin_hit_r, fin_hit_nxt;
  logic              fin_neg_r, fin_neg_nxt;
  logic              fin_all_r, fin_all_nxt;
  logic              fin_sat_r, fin_sat_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [ROW_W-1:0]  out_row_r, out_row_nxt;
  logic              out_hit_r, out_hit_nxt;
  logic              out_aggv_r, out_aggv_nxt;
  logic [DATA_W-1:0] out_val_r, out_val_nxt;
  logic              out_all_r, out_all_nxt;
  logic              out_sat_r, out_sat_nxt;

  acc_t              sel;
  logic              sel_all;
  logic              out_free;
  logic [DATA_W-1:0] sum_mag;
  div_req_t          div_req;
  logic              div_busy;
  logic [DATA_W-1:0] div_quo;

  cfa_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .busy     (div_busy),
    .quotient (div_quo)
  );

  // Matched set when anything matched, otherwise all non-null rows
  assign sel_all  = match_r.count == '0;
  assign sel      = sel_all ? total_r : match_r;
  assign sum_mag  = sel.sum[DATA_W-1] ? (~sel.sum + DATA_W'(1)) : sel.sum;
  assign out_free = !out_valid_r || out_ready;
  assign pop      = (state_r == ST_RUN) && !fifo_stat.empty && out_free;

  assign out_valid           = out_valid_r;
  assign out_row_index       = OUT_ROW_W'(out_row_r);
  assign out_is_match        = out_hit_r;
  assign out_aggregate_valid = out_aggv_r;
  assign out_aggregate_value = out_val_r;
  assign out_used_all_rows   = out_all_r;
  assign out_sum_saturated   = out_sat_r;

  always_comb begin
    state_nxt        = state_r;
    match_nxt        = match_r;
    total_nxt        = total_r;
    fin_row_nxt      = fin_row_r;
    fin_hit_nxt      = fin_hit_r;
    fin_neg_nxt      = fin_neg_r;
    fin_all_nxt      = fin_all_r;
    fin_sat_nxt      = fin_sat_r;
    out_valid_nxt    = out_valid_r && !out_ready;
    out_row_nxt      = out_row_r;
    out_hit_nxt      = out_hit_r;
    out_aggv_nxt     = out_aggv_r;
    out_val_nxt      = out_val_r;
    out_all_nxt      = out_all_r;
    out_sat_nxt      = out_sat_r;
    div_req.start    = 1'b0;
    div_req.dividend = sum_mag;
    div_req.divisor  = sel.count;

    unique case (state_r)
      ST_RUN: begin
        if (pop) begin
          if (!head.is_null) begin
            total_nxt = acc_add(total_r, head.value);
          end
          if (head.hit) begin
            match_nxt = acc_add(match_r, head.value);
          end
          if (head.last_row) begin
            fin_row_nxt = head.row_index;
            fin_hit_nxt = head.hit;
            state_nxt   = ST_FIN;
          end else begin
            out_valid_nxt = 1'b1;
            out_row_nxt   = head.row_index;
            out_hit_nxt   = head.hit;
            out_aggv_nxt  = 1'b0;
            out_val_nxt   = '0;
            out_all_nxt   = 1'b0;
            out_sat_nxt   = 1'b0;
          end
        end
      end

      ST_FIN: begin
        fin_all_nxt = sel_all;
        fin_neg_nxt = sel.sum[DATA_W-1];
        fin_sat_nxt = sel.sat;
        if (agg_op == AGG_AVG && sel.count != '0) begin
          div_req.start = 1'b1;
          state_nxt     = ST_DIV;
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          out_row_nxt   = fin_row_r;
          out_hit_nxt   = fin_hit_r;
          out_aggv_nxt  = 1'b1;
          out_all_nxt   = sel_all;
          out_sat_nxt   = 1'b0;
          out_val_nxt   = '0;
          unique case (agg_op)
            AGG_COUNT: out_val_nxt = DATA_W'(sel.count);
            AGG_SUM: begin
              out_val_nxt = sel.sum;
              out_sat_nxt = sel.sat;
            end
            AGG_AVG:   out_sat_nxt = sel.sat;
            AGG_MIN:   out_val_nxt = (sel.count != '0) ? sel.lo : '0;
            AGG_MAX:   out_val_nxt = (sel.count != '0) ? sel.hi : '0;
            default: begin
              out_aggv_nxt = 1'b0;
              out_all_nxt  = 1'b0;
            end
          endcase
          match_nxt = ACC_CLEAR;
          total_nxt = ACC_CLEAR;
          state_nxt = ST_RUN;
        end
      end

      ST_DIV: begin
        if (!div_busy && out_free) begin
          out_valid_nxt = 1'b1;
          out_row_nxt   = fin_row_r;
          out_hit_nxt   = fin_hit_r;
          out_aggv_nxt  = 1'b1;
          out_val_nxt   = fin_neg_r ? (~div_quo + DATA_W'(1)) : div_quo;
          out_all_nxt   = fin_all_r;
          out_sat_nxt   = fin_sat_r;
          match_nxt     = ACC_CLEAR;
          total_nxt     = ACC_CLEAR;
          state_nxt     = ST_RUN;
        end
      end

      default: state_nxt = ST_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_RUN;
      match_r     <= ACC_CLEAR;
      total_r     <= ACC_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      match_r     <= match_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
      fin_row_r   <= fin_row_nxt;
      fin_hit_r   <= fin_hit_nxt;
      fin_neg_r   <= fin_neg_nxt;
      fin_all_r   <= fin_all_nxt;
      fin_sat_r   <= fin_sat_nxt;
      out_row_r   <= out_row_nxt;
      out_hit_r   <= out_hit_nxt;
      out_aggv_r  <= out_aggv_nxt;
      out_val_r   <= out_val_nxt;
      out_all_r   <= out_all_nxt;
      out_sat_r   <= out_sat_nxt;
    end
  end

endmodule

>>> hw/rtl/column_filter_aggregate.sv
// Top level of the column filter/aggregate block: config registers and wiring.
//
// Usage:
//   in_*  : one row per transaction (value, null flag, last-row mark).
//   out_* : one result per row: row index, match flag, and on the last row
//           the selected aggregate with its used-all-rows and saturation flags.
//   cfg_* : write enable, register index, 64-bit write data; write only
//           while no transaction is in flight.
// Path: an ordinary row reaches out_* via the queue and the result register.
//   The last row also passes the finishing state and, for avg, the divide
//   state, where the serial divider produces one quotient bit per cycle.
// Throughput: one row per cycle within a column while out_ready is high;
//   the last row of a column holds the back end in its finishing states
//   while the 4-entry queue keeps accepting rows until it fills.
// Reset (synchronous, active low) clears the row counter, accumulators and
//   queue and loads predicate never-matches, bounds 0, aggregate count.
// When out_ready is low the result register holds; the queue fills and
//   in_ready drops once it is full.
`timescale 1ns / 1ps
module column_filter_aggregate (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [cfa_pkg::DATA_W-1:0]    in_cell_value,
  input  logic                                 in_cell_is_null,
  input  logic                                 in_last_row,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [cfa_pkg::OUT_ROW_W-1:0]        out_row_index,
  output logic                                 out_is_match,
  output logic                                 out_aggregate_valid,
  output logic signed [cfa_pkg::DATA_W-1:0]    out_aggregate_value,
  output logic                                 out_used_all_rows,
  output logic                                 out_sum_saturated,
  input  logic                                 cfg_we,
  input  logic [cfa_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [cfa_pkg::DATA_W-1:0]           cfg_wdata
);
  import cfa_pkg::*;

  pred_op_t          pred_op_r;
  logic [DATA_W-1:0] bound_low_r, bound_high_r;
  logic [OP_W-1:0]   agg_op_r;

  pred_cfg_t  pred_cfg;
  fifo_stat_t fifo_stat;
  row_entry_t push_entry, head;
  logic       push, pop;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pred_op_r    <= PRED_NEVER;
      bound_low_r  <= '0;
      bound_high_r <= '0;
      agg_op_r     <= AGG_COUNT;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_PRED_OP:    pred_op_r    <= pred_op_t'(cfg_wdata[OP_W-1:0]);
        CFG_BOUND_LOW:  bound_low_r  <= cfg_wdata;
        CFG_BOUND_HIGH: bound_high_r <= cfg_wdata;
        CFG_AGG_OP:     agg_op_r     <= cfg_wdata[OP_W-1:0];
        default: ;
      endcase
    end
  end

  assign pred_cfg = '{op: pred_op_r, low: bound_low_r, high: bound_high_r};

  cfa_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_cell_value   (in_cell_value),
    .in_cell_is_null (in_cell_is_null),
    .in_last_row     (in_last_row),
    .pred_cfg        (pred_cfg),
    .fifo_stat       (fifo_stat),
    .push            (push),
    .push_entry      (push_entry)
  );

  cfa_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .stat       (fifo_stat)
  );

  cfa_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .fifo_stat           (fifo_stat),
    .head                (head),
    .pop                 (pop),
    .agg_op              (agg_op_r),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_row_index       (out_row_index),
    .out_is_match        (out_is_match),
    .out_aggregate_valid (out_aggregate_valid),
    .out_aggregate_value (out_aggregate_value),
    .out_used_all_rows   (out_used_all_rows),
    .out_sum_saturated   (out_sum_saturated)
  );

endmodule

>>> hw/rtl/cfa_checker.sv
// Port-level checker for the column filter/aggregate block, bound to the top.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module cfa_checker (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_valid,
  input logic                                 in_ready,
  input logic signed [cfa_pkg::DATA_W-1:0]    in_cell_value,
  input logic                                 in_cell_is_null,
  input logic                                 in_last_row,
  input logic                                 out_valid,
  input logic                                 out_ready,
  input logic [cfa_pkg::OUT_ROW_W-1:0]        out_row_index,
  input logic                                 out_is_match,
  input logic                                 out_aggregate_valid,
  input logic signed [cfa_pkg::DATA_W-1:0]    out_aggregate_value,
  input logic                                 out_used_all_rows,
  input logic                                 out_sum_saturated,
  input logic                                 cfg_we,
  input logic [cfa_pkg::CFG_IDX_W-1:0]        cfg_index,
  input logic [cfa_pkg::DATA_W-1:0]           cfg_wdata
);

  // A stalled result stays offered
  `CFA_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)

  // A stalled result keeps its row index and aggregate value
  `CFA_ASSERT_NXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(out_row_index) && $stable(out_aggregate_value))

  // Without an aggregate, all aggregate fields are zero
  `CFA_ASSERT_IMP(a_agg_zero, clk, rst_n, out_valid && !out_aggregate_valid, (out_aggregate_value == '0) && !out_used_all_rows && !out_sum_saturated)

  // Saturation is only reported with an aggregate
  `CFA_ASSERT_IMP(a_sat_agg, clk, rst_n, out_valid && out_sum_saturated, out_aggregate_valid)

  // A matching last row means the matched set was used
  `CFA_ASSERT_IMP(a_match_set, clk, rst_n, out_valid && out_is_match && out_aggregate_valid, !out_used_all_rows)

endmodule

bind column_filter_aggregate cfa_checker u_cfa_checker (.*);

>>> test/column_filter_aggregate_checker.sv
// Result checker for the column filter/aggregate block: shadow predictor and in-order scoreboard.
`timescale 1ns / 1ps
module column_filter_aggregate_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  logic signed [cfa_pkg::DATA_W-1:0] in_cell_value,
  input  logic                              in_cell_is_null,
  input  logic                              in_last_row,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  logic [cfa_pkg::OUT_ROW_W-1:0]     out_row_index,
  input  logic                              out_is_match,
  input  logic                              out_aggregate_valid,
  input  logic signed [cfa_pkg::DATA_W-1:0] out_aggregate_value,
  input  logic                              out_used_all_rows,
  input  logic                              out_sum_saturated,
  input  logic                              cfg_we,
  input  logic [cfa_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [cfa_pkg::DATA_W-1:0]        cfg_wdata,
  output int unsigned                       mismatches,
  output int unsigned                       outstanding
);
  import cfa_pkg::*;

  localparam int unsigned REPORT_LIMIT = 10;

  // Running figures of one row set (matched rows or all non-null rows)
  typedef struct packed {
    logic [CNT_W-1:0]  count;
    logic [DATA_W-1:0] sum;
    logic [DATA_W-1:0] lo;
    logic [DATA_W-1:0] hi;
    logic              sat;
  } col_acc_t;

  // What the block reports for one row
  typedef struct packed {
    logic [OUT_ROW_W-1:0] row_index;
    logic                 is_match;
    logic                 agg_valid;
    logic [DATA_W-1:0]    agg_value;
    logic                 used_all;
    logic                 sum_sat;
  } row_result_t;

  // Shadow registers and column state
  pred_op_t             pred_op;
  logic [DATA_W-1:0]    bound_lo;
  logic [DATA_W-1:0]    bound_hi;
  logic [OP_W-1:0]      agg_sel;
  logic [OUT_ROW_W-1:0] row_pos;
  col_acc_t             match_acc;
  col_acc_t             total_acc;

  row_result_t expected_rows[$];
  int unsigned fail_total;

  function automatic col_acc_t acc_empty();
    col_acc_t a;
    a.count = '0;
    a.sum   = '0;
    a.lo    = SUM_MAX;
    a.hi    = SUM_MIN;
    a.sat   = 1'b0;
    return a;
  endfunction

  // Fold one value in: saturating count, clamped sum with sticky flag, extremes
  function automatic col_acc_t acc_fold(col_acc_t a, logic [DATA_W-1:0] v);
    logic [DATA_W:0] wide;
    col_acc_t        r;
    r = a;
    if (a.count != COUNT_MAX) r.count = a.count + 1'b1;
    wide = {a.sum[DATA_W-1], a.sum} + {v[DATA_W-1], v};
    if (wide[DATA_W] != wide[DATA_W-1]) begin
      r.sum = wide[DATA_W] ? SUM_MIN : SUM_MAX;
      r.sat = 1'b1;
    end else begin
      r.sum = wide[DATA_W-1:0];
    end
    if ($signed(v) < $signed(a.lo)) r.lo = v;
    if ($signed(v) > $signed(a.hi)) r.hi = v;
    return r;
  endfunction

  // Classify one row, update the accumulators, and close the column on the last row
  function automatic row_result_t filter_and_aggregate(logic [DATA_W-1:0] cell_val,
                                                       logic is_null, logic last);
    row_result_t              res;
    col_acc_t                 sel;
    logic                     hit;
    logic signed [DATA_W-1:0] sv;
    logic signed [DATA_W-1:0] lo;
    logic signed [DATA_W-1:0] hi;
    logic [DATA_W-1:0]        mag;
    logic [DATA_W-1:0]        quo;
    sv  = cell_val;
    lo  = bound_lo;
    hi  = bound_hi;
    res = '0;
    hit = 1'b0;
    res.row_index = row_pos;
    if (!is_null) begin
      case (pred_op)
        PRED_EQ:      hit = (sv == lo);
        PRED_NE:      hit = (sv != lo);
        PRED_LT:      hit = (sv < lo);
        PRED_GT:      hit = (sv > lo);
        PRED_LE:      hit = (sv <= lo);
        PRED_GE:      hit = (sv >= lo);
        PRED_BETWEEN: hit = (sv >= lo) && (sv <= hi);
        default:      hit = 1'b0;
      endcase
      total_acc = acc_fold(total_acc, cell_val);
      if (hit) match_acc = acc_fold(match_acc, cell_val);
    end
    res.is_match = hit;
    row_pos = row_pos + 1'b1;
    if (last) begin
      // fall back to all rows when nothing matched
      res.used_all  = (match_acc.count == '0);
      sel           = res.used_all ? total_acc : match_acc;
      res.agg_valid = 1'b1;
      case (agg_sel)
        AGG_COUNT: res.agg_value = {{(DATA_W-CNT_W){1'b0}}, sel.count};
        AGG_SUM: begin
          res.agg_value = sel.sum;
          res.sum_sat   = sel.sat;
        end
        AGG_AVG: begin
          // magnitude divide, then restore sign: truncates toward zero
          if (sel.count != '0) begin
            mag = sel.sum[DATA_W-1] ? (~sel.sum + 1'b1) : sel.sum;
            quo = mag / {{(DATA_W-CNT_W){1'b0}}, sel.count};
            res.agg_value = sel.sum[DATA_W-1] ? (~quo + 1'b1) : quo;
          end
          res.sum_sat = sel.sat;
        end
        AGG_MIN: if (sel.count != '0) res.agg_value = sel.lo;
        AGG_MAX: if (sel.count != '0) res.agg_value = sel.hi;
        default: begin
          res.agg_valid = 1'b0;
          res.used_all  = 1'b0;
        end
      endcase
      row_pos   = '0;
      match_acc = acc_empty();
      total_acc = acc_empty();
    end
    return res;
  endfunction

  // Watch config writes, accepted rows and accepted results
  always @(posedge clk) begin : scoreboard
    row_result_t want;
    row_result_t got;
    if (!rst_n) begin
      pred_op    = PRED_NEVER;
      bound_lo   = '0;
      bound_hi   = '0;
      agg_sel    = AGG_COUNT;
      row_pos    = '0;
      match_acc  = acc_empty();
      total_acc  = acc_empty();
      fail_total = 0;
      expected_rows.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_PRED_OP:    pred_op  = pred_op_t'(cfg_wdata[OP_W-1:0]);
          CFG_BOUND_LOW:  bound_lo = cfg_wdata;
          CFG_BOUND_HIGH: bound_hi = cfg_wdata;
          CFG_AGG_OP:     agg_sel  = cfg_wdata[OP_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        expected_rows.push_back(filter_and_aggregate(in_cell_value, in_cell_is_null,
                                                     in_last_row));
      if (out_valid && out_ready) begin
        got.row_index = out_row_index;
        got.is_match  = out_is_match;
        got.agg_valid = out_aggregate_valid;
        got.agg_value = out_aggregate_value;
        got.used_all  = out_used_all_rows;
        got.sum_sat   = out_sum_saturated;
        if (expected_rows.size() == 0) begin
          fail_total++;
          if (fail_total <= REPORT_LIMIT)
            $display("unexpected result transaction: row %0d, nothing outstanding",
                     out_row_index);
        end else begin
          want = expected_rows.pop_front();
          if (got !== want) begin
            fail_total++;
            if (fail_total <= REPORT_LIMIT) begin
              $display("mismatch expected: row %0d match %0b agg %0b value %0d all %0b sat %0b",
                       want.row_index, want.is_match, want.agg_valid,
                       $signed(want.agg_value), want.used_all, want.sum_sat);
              $display("         actual:   row %0d match %0b agg %0b value %0d all %0b sat %0b",
                       got.row_index, got.is_match, got.agg_valid,
                       $signed(got.agg_value), got.used_all, got.sum_sat);
            end
          end
        end
      end
    end
    mismatches  <= fail_total;
    outstanding <= expected_rows.size();
  end

endmodule

>>> test/column_filter_aggregate_test.sv
// Testbench top for the column filter/aggregate block: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module column_filter_aggregate_test;
  import cfa_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam int unsigned HOLD_CYCLES  = 200;
  localparam int unsigned RANDOM_ROWS  = 1800;
  localparam int unsigned DRAIN_CYCLES = 100;

  localparam logic [DATA_W-1:0] VAL_MAX = SUM_MAX;
  localparam logic [DATA_W-1:0] VAL_MIN = SUM_MIN;
  localparam logic [OP_W-1:0]   AGG_UNDEFINED = 3'd5;

  // Value shapes for generated cells
  typedef enum int unsigned {
    CELL_ANY, CELL_NEAR, CELL_EDGE, CELL_BIG_POS, CELL_BIG_NEG, CELL_SMALL
  } cell_kind_t;

  logic                        clk;
  logic                        rst_n;
  logic                        in_valid;
  logic                        in_ready;
  logic signed [DATA_W-1:0]    in_cell_value;
  logic                        in_cell_is_null;
  logic                        in_last_row;
  logic                        out_valid;
  logic                        out_ready;
  logic [OUT_ROW_W-1:0]        out_row_index;
  logic                        out_is_match;
  logic                        out_aggregate_valid;
  logic signed [DATA_W-1:0]    out_aggregate_value;
  logic                        out_used_all_rows;
  logic                        out_sum_saturated;
  logic                        cfg_we;
  logic [CFG_IDX_W-1:0]        cfg_index;
  logic [DATA_W-1:0]           cfg_wdata;

  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned rows_sent;
  logic        idle_on;
  logic        hold_req;

  column_filter_aggregate i_dut (.*);

  column_filter_aggregate_checker i_checker (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog
  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Test completed with failures");
    $finish;
  end

  // Mostly short gaps, a few long ones
  function automatic int unsigned gap_len();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  function automatic logic [DATA_W-1:0] pick_cell(cell_kind_t kind, logic [DATA_W-1:0] anchor);
    logic [DATA_W-1:0] r;
    r = {$urandom, $urandom};
    case (kind)
      CELL_ANY:     return r;
      CELL_NEAR:    return anchor + DATA_W'($urandom_range(0, 8)) - DATA_W'(4);
      CELL_EDGE: begin
        case ($urandom_range(0, 6))
          0: return VAL_MIN;
          1: return VAL_MAX;
          2: return VAL_MIN + 1'b1;
          3: return VAL_MAX - 1'b1;
          4: return '0;
          5: return '1;
          default: return DATA_W'(1);
        endcase
      end
      CELL_BIG_POS: return {2'b01, r[DATA_W-3:0]};
      CELL_BIG_NEG: return {2'b10, r[DATA_W-3:0]};
      default:      return DATA_W'($urandom_range(0, 200)) - DATA_W'(100);
    endcase
  endfunction

  // Result side: random stalls, plus the long hold-off on request
  initial begin : result_sink
    int unsigned stall;
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        stall = idle_on ? gap_len() : 0;
        if (stall != 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic write_reg(cfg_idx_t idx, logic [DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  task automatic configure(pred_op_t pred, logic [DATA_W-1:0] lo, logic [DATA_W-1:0] hi,
                           logic [OP_W-1:0] agg);
    write_reg(CFG_PRED_OP, {{(DATA_W-OP_W){1'b0}}, pred});
    write_reg(CFG_BOUND_LOW, lo);
    write_reg(CFG_BOUND_HIGH, hi);
    write_reg(CFG_AGG_OP, {{(DATA_W-OP_W){1'b0}}, agg});
    cfg_we <= 1'b0;
  endtask

  // One row transaction, then an optional gap
  task automatic send_row(logic [DATA_W-1:0] cell_val, logic is_null, logic last);
    int unsigned gap;
    in_valid        <= 1'b1;
    in_cell_value   <= cell_val;
    in_cell_is_null <= is_null;
    in_last_row     <= last;
    do @(posedge clk); while (!in_ready);
    rows_sent++;
    gap = idle_on ? gap_len() : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_column(int unsigned len, cell_kind_t kind, logic [DATA_W-1:0] anchor,
                             int unsigned null_pct);
    cell_kind_t mix;
    for (int unsigned k = 0; k < len; k++) begin
      mix = ($urandom_range(0, 9) < 7) ? kind : cell_kind_t'($urandom_range(0, 5));
      send_row(pick_cell(mix, anchor), $urandom_range(0, 99) < null_pct, k == len - 1);
    end
  endtask

  // Stop offering and wait until every expected result has arrived
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  initial begin : stimulus
    logic [DATA_W-1:0] lo;
    logic [DATA_W-1:0] hi;
    int unsigned       phase;
    int unsigned       len;
    in_valid        <= 1'b0;
    in_cell_value   <= '0;
    in_cell_is_null <= 1'b0;
    in_last_row     <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_index       <= CFG_PRED_OP;
    cfg_wdata       <= '0;
    rst_n           <= 1'b0;
    idle_on   = 1'b1;
    hold_req  = 1'b0;
    rows_sent = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: never matches, count over all rows, null last row
    send_row(DATA_W'(5), 1'b0, 1'b0);
    send_row('0, 1'b1, 1'b1);
    drain();
    // Sum saturating high
    configure(PRED_EQ, VAL_MAX, '0, AGG_SUM);
    send_row(VAL_MAX, 1'b0, 1'b0);
    send_row(VAL_MAX, 1'b0, 1'b1);
    drain();
    // Average of a sum saturated low
    configure(PRED_NE, '0, '0, AGG_AVG);
    send_row(VAL_MIN, 1'b0, 1'b0);
    send_row(VAL_MIN, 1'b0, 1'b1);
    drain();
    configure(PRED_LT, '0, '0, AGG_MIN);
    send_row(VAL_MIN, 1'b0, 1'b0);
    send_row(DATA_W'(7), 1'b0, 1'b1);
    drain();
    configure(PRED_GT, '1, '0, AGG_MAX);
    send_row(VAL_MAX, 1'b0, 1'b0);
    send_row('0, 1'b0, 1'b1);
    drain();
    configure(PRED_LE, VAL_MIN, '0, AGG_COUNT);
    send_row(VAL_MIN, 1'b0, 1'b0);
    send_row('0, 1'b1, 1'b1);
    drain();
    // No match: average over all rows
    configure(PRED_GE, VAL_MAX, '0, AGG_AVG);
    send_row(DATA_W'(100), 1'b0, 1'b0);
    send_row(DATA_W'(3), 1'b0, 1'b1);
    drain();
    // Between, both bounds inclusive
    configure(PRED_BETWEEN, -64'sd10, 64'sd10, AGG_SUM);
    send_row(-64'sd10, 1'b0, 1'b0);
    send_row(64'sd10, 1'b0, 1'b0);
    send_row(64'sd11, 1'b0, 1'b1);
    drain();
    // Between with inverted bounds never matches
    configure(PRED_BETWEEN, 64'sd5, -64'sd5, AGG_MAX);
    send_row('0, 1'b0, 1'b0);
    send_row(DATA_W'(1), 1'b0, 1'b1);
    drain();
    // Undefined aggregate code
    configure(PRED_NEVER, '0, '0, AGG_UNDEFINED);
    send_row(DATA_W'(1), 1'b0, 1'b1);
    drain();
    // Empty set
    configure(PRED_EQ, '0, '0, AGG_MIN);
    send_row('0, 1'b1, 1'b1);
    drain();
    // Negative average truncates toward zero
    configure(PRED_NEVER, '0, '0, AGG_AVG);
    send_row(-64'sd7, 1'b0, 1'b0);
    send_row(64'sd2, 1'b0, 1'b1);
    drain();

    // Random phases: fresh settings, then a few columns
    rows_sent = 0;
    phase     = 0;
    while (rows_sent < RANDOM_ROWS) begin
      lo = pick_cell(cell_kind_t'($urandom_range(0, 5)), '0);
      hi = $urandom_range(0, 1) ? lo + DATA_W'($urandom_range(0, 64))
                                : pick_cell(cell_kind_t'($urandom_range(0, 5)), '0);
      configure(pred_op_t'($urandom_range(0, 7)), lo, hi, OP_W'($urandom_range(0, 7)));
      if (phase == 6) begin
        // receiver holds off while rows keep coming: queue fills, input stalls
        idle_on  = 1'b0;
        hold_req = 1'b1;
        send_column(60, CELL_NEAR, lo, 8);
      end else begin
        idle_on = ($urandom_range(0, 3) != 0);
        repeat ($urandom_range(1, 3)) begin
          len = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 30);
          send_column(len, cell_kind_t'($urandom_range(0, 5)), lo,
                      ($urandom_range(0, 4) == 0) ? 60 : 8);
        end
      end
      drain();
      phase++;
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
